>>> src/srpd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package srpd_pkg;

    // Parse phases
    localparam logic [1:0] PH_LOW  = 2'd0;
    localparam logic [1:0] PH_HIGH = 2'd1;
    localparam logic [1:0] PH_RUN  = 2'd2;
    localparam logic [1:0] PH_DONE = 2'd3;

    // Command codes of the 16-bit command word
    localparam logic [1:0] CMD_SET_X   = 2'd0;
    localparam logic [1:0] CMD_RUN     = 2'd1;
    localparam logic [1:0] CMD_SET_Y   = 2'd2;
    localparam logic [1:0] CMD_END     = 2'd3;

    // Result kinds
    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_END   = 1'b1;

    // Ramp selectors
    localparam logic [1:0] RAMP_ONE   = 2'd0;
    localparam logic [1:0] RAMP_TWO   = 2'd1;
    localparam logic [1:0] RAMP_THREE = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_STREAM_LENGTH = 2'd0;
    localparam logic [1:0] CFG_RAMP_ONE      = 2'd1;
    localparam logic [1:0] CFG_RAMP_TWO      = 2'd2;
    localparam logic [1:0] CFG_RAMP_THREE    = 2'd3;

    // Ramp boundaries on the pixel byte
    localparam logic [7:0] RAMP_TWO_BASE   = 8'd16;
    localparam logic [7:0] RAMP_THREE_BASE = 8'd32;

    // x / 15 == (x * 34953) >> 19 for every x below 2^16
    localparam logic [15:0] RECIP_15    = 16'd34953;
    localparam int          RECIP_SHIFT = 19;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic        kind;
        logic [14:0] pos_x;
        logic [13:0] pos_y;
        logic [7:0]  level;
        logic [1:0]  ramp;
        logic [14:0] width;
        logic [14:0] height;
    } srpd_entry_t;

    typedef struct packed {
        logic        push;
        srpd_entry_t entry;
    } srpd_push_t;

endpackage

`default_nettype wire

>>> src/srpd_front.sv
`timescale 1ns / 1ps
`default_nettype none

// Byte parser: decodes command words, tracks cursor and extents, and queues
// one entry per pixel byte or sprite end.
module srpd_front
    import srpd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_fire,
    input  wire logic [7:0]  in_byte,
    input  wire logic [15:0] stream_length,
    output srpd_push_t       push_out
);

    logic [1:0]  phase_reg,      phase_next;
    logic [7:0]  low_hold_reg,   low_hold_next;
    logic [14:0] cursor_x_reg,   cursor_x_next;
    logic [13:0] cursor_y_reg,   cursor_y_next;
    logic [13:0] run_rem_reg,    run_rem_next;
    logic [15:0] taken_reg,      taken_next;
    logic [14:0] max_width_reg,  max_width_next;
    logic [14:0] max_height_reg, max_height_next;

    logic [15:0] word;
    logic [1:0]  cmd;
    logic [13:0] value;
    logic [14:0] value_inc;
    logic [14:0] x_inc;
    logic [13:0] run_dec;

    assign word      = {in_byte, low_hold_reg};
    assign cmd       = word[1:0];
    assign value     = word[15:2];
    assign value_inc = {1'b0, value} + 15'd1;
    assign x_inc     = cursor_x_reg + 15'd1;
    assign run_dec   = run_rem_reg - 14'd1;

    always_comb
    begin
        phase_next      = phase_reg;
        low_hold_next   = low_hold_reg;
        cursor_x_next   = cursor_x_reg;
        cursor_y_next   = cursor_y_reg;
        run_rem_next    = run_rem_reg;
        taken_next      = taken_reg;
        max_width_next  = max_width_reg;
        max_height_next = max_height_reg;

        push_out              = '0;
        push_out.entry.pos_x  = cursor_x_reg;
        push_out.entry.pos_y  = cursor_y_reg;

        if (in_fire && (phase_reg != PH_DONE))
        begin
            if (taken_reg >= stream_length)
            begin
                // Byte budget spent: drop the byte and close the sprite
                push_out.push         = 1'b1;
                push_out.entry        = '0;
                push_out.entry.kind   = KIND_END;
                push_out.entry.width  = max_width_reg;
                push_out.entry.height = max_height_reg;
                phase_next            = PH_DONE;
            end
            else
            begin
                taken_next = taken_reg + 16'd1;
                unique case (phase_reg)
                    PH_LOW:
                    begin
                        low_hold_next = in_byte;
                        phase_next    = PH_HIGH;
                    end
                    PH_HIGH:
                    begin
                        phase_next = PH_LOW;
                        unique case (cmd)
                            CMD_SET_X:
                            begin
                                cursor_x_next = {1'b0, value};
                            end
                            CMD_SET_Y:
                            begin
                                cursor_y_next = value;
                                if (value_inc > max_height_reg)
                                begin
                                    max_height_next = value_inc;
                                end
                            end
                            CMD_END:
                            begin
                                push_out.push         = 1'b1;
                                push_out.entry        = '0;
                                push_out.entry.kind   = KIND_END;
                                push_out.entry.width  = max_width_reg;
                                push_out.entry.height = max_height_reg;
                                phase_next            = PH_DONE;
                            end
                            CMD_RUN:
                            begin
                                if (value == 14'd0)
                                begin
                                    cursor_x_next = '0;
                                end
                                else
                                begin
                                    run_rem_next = value;
                                    phase_next   = PH_RUN;
                                end
                            end
                            default:
                            begin
                                phase_next = PH_LOW;
                            end
                        endcase
                    end
                    PH_RUN:
                    begin
                        push_out.push       = 1'b1;
                        push_out.entry.kind = KIND_PIXEL;
                        if (in_byte < RAMP_TWO_BASE)
                        begin
                            push_out.entry.ramp  = RAMP_ONE;
                            push_out.entry.level = in_byte;
                        end
                        else if (in_byte < RAMP_THREE_BASE)
                        begin
                            push_out.entry.ramp  = RAMP_TWO;
                            push_out.entry.level = in_byte - RAMP_TWO_BASE;
                        end
                        else
                        begin
                            push_out.entry.ramp  = RAMP_THREE;
                            push_out.entry.level = in_byte - RAMP_THREE_BASE;
                        end
                        cursor_x_next = x_inc;
                        if (x_inc > max_width_reg)
                        begin
                            max_width_next = x_inc;
                        end
                        run_rem_next = run_dec;
                        if (run_dec == 14'd0)
                        begin
                            cursor_x_next = '0;
                            phase_next    = PH_LOW;
                        end
                    end
                    default:
                    begin
                        phase_next = phase_reg;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_LOW;
            low_hold_reg   <= '0;
            cursor_x_reg   <= '0;
            cursor_y_reg   <= '0;
            run_rem_reg    <= '0;
            taken_reg      <= '0;
            max_width_reg  <= '0;
            max_height_reg <= '0;
        end
        else
        begin
            phase_reg      <= phase_next;
            low_hold_reg   <= low_hold_next;
            cursor_x_reg   <= cursor_x_next;
            cursor_y_reg   <= cursor_y_next;
            run_rem_reg    <= run_rem_next;
            taken_reg      <= taken_next;
            max_width_reg  <= max_width_next;
            max_height_reg <= max_height_next;
        end
    end

endmodule

`default_nettype wire

>>> src/srpd_queue.sv
`timescale 1ns / 1ps
`default_nettype none

// Small FIFO between parser and color stage.
module srpd_queue
    import srpd_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire srpd_push_t push_in,
    output logic       full,
    input  wire logic  pop,
    output logic       head_valid,
    output srpd_entry_t head
);

    srpd_entry_t         mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_AW:0]   count_reg,  count_next;
    logic                do_pop;

    assign full       = (count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = mem[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + (QUEUE_AW)'(push_in.push);
        rd_ptr_next = rd_ptr_reg + (QUEUE_AW)'(do_pop);
        count_next  = count_reg + (QUEUE_AW+1)'(push_in.push) - (QUEUE_AW+1)'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (push_in.push)
        begin
            mem[wr_ptr_reg] <= push_in.entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

>>> src/srpd_back.sv
`timescale 1ns / 1ps
`default_nettype none

// Color stage: level * component, then divide by 15 through a reciprocal,
// into the output register. The whole stage stalls when the output is held.
module srpd_back
    import srpd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        head_valid,
    input  wire srpd_entry_t head,
    output logic             pop,
    input  wire logic [23:0] ramp_one_color,
    input  wire logic [23:0] ramp_two_color,
    input  wire logic [23:0] ramp_three_color,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [87:0]      m_tdata,
    output logic [0:0]       m_tuser
);

    logic        advance;
    logic [23:0] color;

    // Product stage
    logic        a_valid_reg;
    srpd_entry_t a_entry_reg;
    logic [15:0] a_red_reg, a_green_reg, a_blue_reg;

    // Output register
    logic        o_valid_reg;
    logic        o_kind_reg;
    logic [14:0] o_x_reg;
    logic [13:0] o_y_reg;
    logic [7:0]  o_red_reg, o_green_reg, o_blue_reg;
    logic [14:0] o_width_reg, o_height_reg;

    logic [31:0] q_red, q_green, q_blue;

    assign advance = !o_valid_reg || m_tready;
    assign pop     = advance;

    always_comb
    begin
        case (head.ramp)
            RAMP_ONE:   color = ramp_one_color;
            RAMP_TWO:   color = ramp_two_color;
            default:    color = ramp_three_color;
        endcase
    end

    assign q_red   = a_red_reg   * RECIP_15;
    assign q_green = a_green_reg * RECIP_15;
    assign q_blue  = a_blue_reg  * RECIP_15;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            a_entry_reg  <= head;
            a_red_reg    <= head.level * color[23:16];
            a_green_reg  <= head.level * color[15:8];
            a_blue_reg   <= head.level * color[7:0];
            o_kind_reg   <= a_entry_reg.kind;
            o_x_reg      <= a_entry_reg.pos_x;
            o_y_reg      <= a_entry_reg.pos_y;
            o_width_reg  <= a_entry_reg.width;
            o_height_reg <= a_entry_reg.height;
            o_red_reg    <= q_red[RECIP_SHIFT +: 8];
            o_green_reg  <= q_green[RECIP_SHIFT +: 8];
            o_blue_reg   <= q_blue[RECIP_SHIFT +: 8];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            a_valid_reg <= head_valid;
            o_valid_reg <= a_valid_reg;
        end
    end

    assign m_tvalid = o_valid_reg;
    assign m_tuser  = o_kind_reg;
    assign m_tdata  = {5'd0, o_height_reg, o_width_reg, o_blue_reg, o_green_reg,
                       o_red_reg, o_y_reg, o_x_reg};

endmodule

`default_nettype wire

>>> src/sprite_rle_pixel_decoder_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Path: a pixel or end result is written to the queue as its byte is accepted,
//   then passes the product register and the output register to m_tvalid.
// Throughput: one byte per cycle while the queue has room; the parser never holds a
//   byte, and the four-entry queue and two-stage color pipeline absorb output stalls.
// Reset: rst_n clears parser state, queue pointers, pipeline valids and all
//   configuration registers asynchronously; no clearing pass.
module sprite_rle_pixel_decoder_top
    import srpd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Input byte stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] stream_byte
    // Result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [87:0]      m_tdata,   // [14:0] pos_x, [28:15] pos_y, [36:29] red,
                                        // [44:37] green, [52:45] blue,
                                        // [67:53] width, [82:68] height, rest zero
    output logic [0:0]       m_tuser,   // [0] kind: 0 pixel, 1 end of sprite
    // Configuration writes
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [23:0] cfg_data
);

    logic [15:0] stream_length_reg;
    logic [23:0] ramp_one_reg;
    logic [23:0] ramp_two_reg;
    logic [23:0] ramp_three_reg;

    srpd_push_t  push;
    logic        queue_full;
    logic        head_valid;
    srpd_entry_t head;
    logic        pop;
    logic        in_fire;

    // Take a byte whenever the queue has room; each byte adds at most one entry.
    assign s_tready = !queue_full;
    assign in_fire  = s_tvalid && s_tready;

    // Configuration registers; user writes only while the block is idle; not enforced.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stream_length_reg <= '0;
            ramp_one_reg      <= '0;
            ramp_two_reg      <= '0;
            ramp_three_reg    <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_STREAM_LENGTH: stream_length_reg <= cfg_data[15:0];
                CFG_RAMP_ONE:      ramp_one_reg      <= cfg_data;
                CFG_RAMP_TWO:      ramp_two_reg      <= cfg_data;
                CFG_RAMP_THREE:    ramp_three_reg    <= cfg_data;
                default:           ramp_three_reg    <= ramp_three_reg;
            endcase
        end
    end

    // Front: parse command words, track cursor and extents.
    srpd_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_fire       (in_fire),
        .in_byte       (s_tdata),
        .stream_length (stream_length_reg),
        .push_out      (push)
    );

    // Decouple parsing from color scaling and output backpressure.
    srpd_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_in    (push),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    // Back: scale ramp color by level / 15 and hold the result transaction.
    srpd_back u_back
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .head_valid       (head_valid),
        .head             (head),
        .pop              (pop),
        .ramp_one_color   (ramp_one_reg),
        .ramp_two_color   (ramp_two_reg),
        .ramp_three_color (ramp_three_reg),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .m_tdata          (m_tdata),
        .m_tuser          (m_tuser)
    );

endmodule

`default_nettype wire

>>> bench/tb_sprite_rle_pixel_decoder_top.sv
`timescale 1ns / 1ps

module tb_sprite_rle_pixel_decoder_top
    import srpd_pkg::*;
;

    localparam int STREAM_ITEMS = 1800;       // stream bytes before the sprite end
    localparam int CYCLE_LIMIT  = 1_000_000;  // slowest legal run is well below this
    localparam int DRAIN_CYCLES = 8;          // settle time once no result is owed

    // One decoded result as it leaves the block, unpacked from tdata/tuser
    typedef struct packed {
        logic        kind;
        logic [14:0] pos_x;
        logic [13:0] pos_y;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [14:0] width;
        logic [14:0] height;
    } decoded_result_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;     // [7:0] stream_byte
    logic        m_tvalid;
    logic        m_tready;
    logic [87:0] m_tdata;     // [14:0] pos_x, [28:15] pos_y, [36:29] red, [44:37] green,
                              // [52:45] blue, [67:53] width, [82:68] height
    logic [0:0]  m_tuser;     // [0] kind
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [23:0] cfg_data;

    // Decoder shadow: the state the block should hold after every accepted byte
    logic [1:0]  dec_phase;
    logic [7:0]  held_low;
    logic [14:0] col;
    logic [13:0] row;
    logic [13:0] run_left;
    logic [15:0] taken;
    logic [14:0] widest;
    logic [14:0] tallest;
    logic [15:0] cfg_len;
    logic [23:0] ramp_color [0:2];

    // Results the block still owes, oldest first
    decoded_result_t pending_results [$];

    int    items_sent;
    int    pixels_seen;
    int    ends_seen;
    int    mismatches;
    int    cycle_count;
    int    hold_off_left;
    int    ready_gap_left;
    bit    idling_on;
    string end_how;

    sprite_rle_pixel_decoder_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // Cycle budget: end the run if the block hangs
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Gap length: mostly short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 12);
        return $urandom_range(30, 80);
    endfunction

    // Pixel byte: favor the ramp boundaries and the extremes
    function automatic logic [7:0] pick_pixel();
        if ($urandom_range(0, 99) < 25)
        begin
            case ($urandom_range(0, 5))
                0:       return 8'd0;
                1:       return RAMP_TWO_BASE - 8'd1;
                2:       return RAMP_TWO_BASE;
                3:       return RAMP_THREE_BASE - 8'd1;
                4:       return RAMP_THREE_BASE;
                default: return 8'hFF;
            endcase
        end
        return 8'($urandom_range(0, 255));
    endfunction

    // Coordinate value for the x and y commands, extremes included
    function automatic logic [13:0] pick_coord();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return 14'd0;
        else if (r < 20)
            return 14'h3FFF;
        else if (r < 60)
            return 14'($urandom_range(0, 63));
        return 14'($urandom_range(0, 16383));
    endfunction

    function automatic logic [23:0] pick_color();
        case ($urandom_range(0, 4))
            0:       return 24'h000000;
            1:       return 24'hFFFFFF;
            default: return 24'($urandom_range(0, 24'hFFFFFF));
        endcase
    endfunction

    // One color channel: level * component / 15, truncated to 8 bits
    function automatic logic [7:0] scale_channel(input logic [7:0] comp,
                                                 input logic [7:0] level);
        int unsigned prod;
        prod = (int'(level) * int'(comp)) / 15;
        return prod[7:0];
    endfunction

    // Close the sprite: owe an end result carrying the extents
    task automatic finish_sprite();
        decoded_result_t r;
        r = '0;
        r.kind   = KIND_END;
        r.width  = widest;
        r.height = tallest;
        dec_phase = PH_DONE;
        pending_results.push_back(r);
    endtask

    // Advance the decoder shadow by one accepted byte
    task automatic predict_byte(input logic [7:0] b);
        decoded_result_t r;
        logic [15:0]     word;
        logic [13:0]     v;
        logic [14:0]     v_plus;
        logic [23:0]     color;
        logic [7:0]      level;
        if (dec_phase == PH_DONE)
            return;
        // Byte count used up: drop this byte and end the sprite instead
        if (taken >= cfg_len)
        begin
            finish_sprite();
            return;
        end
        taken = taken + 16'd1;
        case (dec_phase)
            PH_LOW:
            begin
                held_low  = b;
                dec_phase = PH_HIGH;
            end
            PH_HIGH:
            begin
                word      = {b, held_low};
                v         = word[15:2];
                dec_phase = PH_LOW;
                case (word[1:0])
                    CMD_SET_X: col = {1'b0, v};
                    CMD_SET_Y:
                    begin
                        row    = v;
                        v_plus = {1'b0, v} + 15'd1;
                        if (v_plus > tallest)
                            tallest = v_plus;
                    end
                    CMD_END:   finish_sprite();
                    default:
                    begin
                        // An empty run only moves the column back to 0
                        if (v == 14'd0)
                            col = 15'd0;
                        else
                        begin
                            run_left  = v;
                            dec_phase = PH_RUN;
                        end
                    end
                endcase
            end
            default:
            begin
                if (b < RAMP_TWO_BASE)
                begin
                    color = ramp_color[RAMP_ONE];
                    level = b;
                end
                else if (b < RAMP_THREE_BASE)
                begin
                    color = ramp_color[RAMP_TWO];
                    level = b - RAMP_TWO_BASE;
                end
                else
                begin
                    color = ramp_color[RAMP_THREE];
                    level = b - RAMP_THREE_BASE;
                end
                r       = '0;
                r.kind  = KIND_PIXEL;
                r.pos_x = col;
                r.pos_y = row;
                r.red   = scale_channel(color[23:16], level);
                r.green = scale_channel(color[15:8], level);
                r.blue  = scale_channel(color[7:0], level);
                pending_results.push_back(r);
                col = col + 15'd1;
                if (col > widest)
                    widest = col;
                run_left = run_left - 14'd1;
                if (run_left == 14'd0)
                begin
                    col       = 15'd0;
                    dec_phase = PH_LOW;
                end
            end
        endcase
    endtask

    // Offer one stream byte, hold it until the transaction completes
    task automatic send_byte(input logic [7:0] value);
        int gap;
        gap = (idling_on && $urandom_range(0, 3) == 0) ? pick_gap() : 0;
        if (gap > 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = value;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_byte(value);
        items_sent++;
        @(negedge clk);
    endtask

    // Command word goes out low byte first
    task automatic send_word(input logic [1:0] cmd, input logic [13:0] v);
        send_byte({v[5:0], cmd});
        send_byte(v[13:6]);
    endtask

    task automatic send_run(input logic [13:0] count);
        send_word(CMD_RUN, count);
        repeat (count) send_byte(pick_pixel());
    endtask

    // Stop offering, wait for every owed result, then let the pipeline settle
    task automatic wait_idle();
        s_tvalid = 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Register write, mirrored into the shadow configuration
    task automatic write_reg(input logic [1:0] idx, input logic [23:0] value);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        case (idx)
            CFG_STREAM_LENGTH: cfg_len = value[15:0];
            CFG_RAMP_ONE:      ramp_color[RAMP_ONE]   = value;
            CFG_RAMP_TWO:      ramp_color[RAMP_TWO]   = value;
            default:           ramp_color[RAMP_THREE] = value;
        endcase
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic note_result_error(input string what, input decoded_result_t want,
                                     input decoded_result_t got);
        mismatches++;
        if (mismatches <= 10)
        begin
            $display("%s at cycle %0d: exp kind=%0d x=%0d y=%0d rgb=%02h%02h%02h w=%0d h=%0d",
                     what, cycle_count, want.kind, want.pos_x, want.pos_y,
                     want.red, want.green, want.blue, want.width, want.height);
            $display("    got kind=%0d x=%0d y=%0d rgb=%02h%02h%02h w=%0d h=%0d",
                     got.kind, got.pos_x, got.pos_y, got.red, got.green, got.blue,
                     got.width, got.height);
        end
    endtask

    // Result checker: compare every completed output transaction with the oldest
    // owed result
    always @(posedge clk)
    begin : result_check
        decoded_result_t got;
        decoded_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.kind   = m_tuser[0];
            got.pos_x  = m_tdata[14:0];
            got.pos_y  = m_tdata[28:15];
            got.red    = m_tdata[36:29];
            got.green  = m_tdata[44:37];
            got.blue   = m_tdata[52:45];
            got.width  = m_tdata[67:53];
            got.height = m_tdata[82:68];
            if (got.kind == KIND_END)
                ends_seen++;
            else
                pixels_seen++;
            if (pending_results.size() == 0)
                note_result_error("Unexpected result", '0, got);
            else
            begin
                want = pending_results.pop_front();
                if (got !== want)
                    note_result_error("Mismatch", want, got);
            end
        end
    end

    // Receiver: random stalls, long hold-off on request, steady when idling is off
    always @(negedge clk)
    begin
        if (hold_off_left > 0)
        begin
            m_tready = 1'b0;
            hold_off_left--;
        end
        else if (!idling_on)
            m_tready = 1'b1;
        else if (ready_gap_left > 0)
        begin
            m_tready = 1'b0;
            ready_gap_left--;
        end
        else
        begin
            m_tready = 1'b1;
            if ($urandom_range(0, 3) == 0)
                ready_gap_left = pick_gap();
        end
    end

    // Directed: every command but the end command, both pixel extremes, ramp
    // boundaries, an empty run, pixels before any row command and the largest row
    task automatic test_directed_commands();
        write_reg(CFG_STREAM_LENGTH, 24'h00FFFF);
        write_reg(CFG_RAMP_ONE, 24'hFFFFFF);
        write_reg(CFG_RAMP_TWO, 24'h0000FF);
        write_reg(CFG_RAMP_THREE, 24'hFFFFFF);
        send_word(CMD_RUN, 14'd2);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_word(CMD_SET_Y, 14'h3FFF);
        send_word(CMD_SET_Y, 14'd0);
        send_word(CMD_SET_X, 14'h3FFF);
        send_word(CMD_RUN, 14'd4);
        send_byte(RAMP_TWO_BASE - 8'd1);
        send_byte(RAMP_TWO_BASE);
        send_byte(RAMP_THREE_BASE - 8'd1);
        send_byte(RAMP_THREE_BASE);
        send_word(CMD_RUN, 14'd0);
        send_run(14'd1);
        wait_idle();
    endtask

    // Long receiver hold-off while the sender keeps pushing pixels back to back
    task automatic test_output_backpressure();
        wait_idle();
        idling_on     = 1'b0;
        hold_off_left = 300;
        send_word(CMD_SET_Y, pick_coord());
        send_run(14'd60);
        // Pause the sender until the block has drained completely
        wait_idle();
        idling_on = 1'b1;
    endtask

    // Random sprite body in phases; ramps change between phases
    task automatic test_random_sprite();
        int phase_idx;
        int target;
        int choice;
        phase_idx = 0;
        while (items_sent < STREAM_ITEMS)
        begin
            wait_idle();
            case (phase_idx % 4)
                0:
                begin
                    write_reg(CFG_RAMP_ONE, 24'hFFFFFF);
                    write_reg(CFG_RAMP_TWO, 24'hFFFFFF);
                    write_reg(CFG_RAMP_THREE, 24'hFFFFFF);
                end
                1:
                begin
                    write_reg(CFG_RAMP_ONE, 24'h000000);
                    write_reg(CFG_RAMP_TWO, pick_color());
                    write_reg(CFG_RAMP_THREE, 24'h000000);
                end
                default:
                begin
                    write_reg(CFG_RAMP_ONE, pick_color());
                    write_reg(CFG_RAMP_TWO, pick_color());
                    write_reg(CFG_RAMP_THREE, pick_color());
                end
            endcase
            // Every third phase runs without any idling on either side
            idling_on = (phase_idx % 3 != 2);
            target    = items_sent + 200;
            while (items_sent < target)
            begin
                choice = $urandom_range(0, 99);
                if (choice < 35)
                    send_run(14'($urandom_range(1, 24)));
                else if (choice < 50)
                    send_word(CMD_SET_Y, pick_coord());
                else if (choice < 65)
                    send_word(CMD_SET_X, pick_coord());
                else if (choice < 85)
                begin
                    send_word(CMD_SET_Y, pick_coord());
                    send_word(CMD_SET_X, pick_coord());
                    send_run(14'($urandom_range(1, 32)));
                end
                else if (choice < 92)
                    send_word(CMD_RUN, 14'd0);
                else
                begin
                    // Noise: back-to-back coordinate words with no pixels between
                    send_word(CMD_SET_X, 14'($urandom_range(0, 16383)));
                    send_word(CMD_SET_Y, 14'($urandom_range(0, 16383)));
                end
            end
            phase_idx++;
        end
        idling_on = 1'b1;
    endtask

    // End the sprite one of four ways, then feed bytes that must be dropped
    task automatic test_sprite_end();
        wait_idle();
        case ($urandom_range(0, 3))
            0:
            begin
                end_how = "end command";
                send_word(CMD_END, pick_coord());
            end
            1:
            begin
                end_how = "byte count used up inside a run";
                send_word(CMD_RUN, 14'd6);
                send_byte(pick_pixel());
                send_byte(pick_pixel());
                wait_idle();
                write_reg(CFG_STREAM_LENGTH, {8'h00, taken});
                send_byte(pick_pixel());
            end
            2:
            begin
                end_how = "byte count lowered to zero inside a word";
                send_byte(8'($urandom_range(0, 255)));
                wait_idle();
                write_reg(CFG_STREAM_LENGTH, 24'h000000);
                send_byte(8'($urandom_range(0, 255)));
            end
            default:
            begin
                end_how = "byte count reached after a word";
                write_reg(CFG_STREAM_LENGTH, {8'h00, taken + 16'd3});
                send_word(CMD_SET_X, pick_coord());
                send_byte(8'($urandom_range(0, 255)));
                send_byte(8'($urandom_range(0, 255)));
            end
        endcase
        repeat (16) send_byte(8'($urandom_range(0, 255)));
        repeat (4) send_byte({6'($urandom_range(0, 63)), CMD_END});
    endtask

    initial
    begin
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = 8'h00;
        m_tready       = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = CFG_STREAM_LENGTH;
        cfg_data       = 24'h000000;
        idling_on      = 1'b1;
        hold_off_left  = 0;
        ready_gap_left = 0;
        items_sent     = 0;
        pixels_seen    = 0;
        ends_seen      = 0;
        mismatches     = 0;
        cycle_count    = 0;
        end_how        = "";
        // Shadow reset matches the block: everything zero
        dec_phase      = PH_LOW;
        held_low       = 8'h00;
        col            = 15'd0;
        row            = 14'd0;
        run_left       = 14'd0;
        taken          = 16'd0;
        widest         = 15'd0;
        tallest        = 15'd0;
        cfg_len        = 16'd0;
        ramp_color[RAMP_ONE]   = 24'h000000;
        ramp_color[RAMP_TWO]   = 24'h000000;
        ramp_color[RAMP_THREE] = 24'h000000;

        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed_commands();
        test_output_backpressure();
        test_random_sprite();
        test_output_backpressure();
        test_sprite_end();

        // Drain: every owed result, then a wait for stray outputs
        wait_idle();
        mismatches += pending_results.size();

        $display("Decoded %0d stream bytes into %0d pixel results and %0d sprite end(s)",
                 items_sent, pixels_seen, ends_seen);
        $display("Sprite closed by %s; %0d mismatches", end_how, mismatches);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
